/* hw/rtl/sxp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxp_pkg
// Shared types and constants for the sysex seven-bit packer: message framing
// bytes, the output step sequence and the job record between front and back.
// ----------------------------------------------------------------------------
package sxp_pkg;

   // framing bytes
   localparam logic [7:0] HDR_START = 8'hF0;
   localparam logic [7:0] HDR_T     = 8'h54;
   localparam logic [7:0] HDR_H     = 8'h48;
   localparam logic [7:0] END_MARK  = 8'hF7;

   // carried residue never exceeds six bits
   localparam logic [2:0] RESIDUE_FULL = 3'd6;

   // one step per emitted byte, in message order
   typedef enum logic [2:0] {
      STEP_START,
      STEP_T,
      STEP_H,
      STEP_ID,
      STEP_CTL,
      STEP_D0,
      STEP_D1,
      STEP_END
   } step_type;

   // work for one accepted payload byte
   typedef struct packed {
      logic       hdr;       // header goes out first
      logic [7:0] msg_id;
      logic [7:0] ctl;
      logic [6:0] d0;        // first packed byte, always sent
      logic [6:0] d1;        // second packed byte or flushed partial byte
      logic       d1_en;     // second byte is sent
      logic       last;      // end marker follows
   } job_type;

endpackage

/* hw/rtl/sxp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxp_front
// Accepts payload bytes, merges them with the carried residue and turns each
// into a job record for the back end. Holds the message and residue state.
// ----------------------------------------------------------------------------
module sxp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       data_byte,
   input  logic [7:0]       msg_id,
   input  logic [7:0]       control_code,
   input  logic             last_byte,
   output logic             push,
   output sxp_pkg::job_type push_job,
   input  logic             queue_full
);

   logic        in_message_ff, in_message_in;
   logic [5:0]  residue_bits_ff, residue_bits_in;
   logic [2:0]  residue_count_ff, residue_count_in;
   logic [2:0]  count;
   logic [5:0]  residue;
   logic [13:0] acc;
   logic        full_pair;

   assign in_ready = !queue_full;
   assign push     = in_valid && !queue_full;

   // merge new byte above the carried bits; a new message starts empty
   always_comb begin
      count     = in_message_ff ? residue_count_ff : 3'd0;
      residue   = in_message_ff ? residue_bits_ff : 6'd0;
      acc       = {8'd0, residue} | ({6'd0, data_byte} << count);
      full_pair = (count == sxp_pkg::RESIDUE_FULL);

      push_job.hdr    = !in_message_ff;
      push_job.msg_id = msg_id;
      push_job.ctl    = control_code;
      push_job.d0     = acc[6:0];
      push_job.d1     = acc[13:7];
      push_job.d1_en  = full_pair || last_byte;
      push_job.last   = last_byte;

      in_message_in    = in_message_ff;
      residue_bits_in  = residue_bits_ff;
      residue_count_in = residue_count_ff;
      if (push) begin
         if (last_byte) begin
            in_message_in    = 1'b0;
            residue_bits_in  = 6'd0;
            residue_count_in = 3'd0;
         end else begin
            in_message_in    = 1'b1;
            residue_bits_in  = full_pair ? 6'd0 : acc[12:7];
            residue_count_in = full_pair ? 3'd0 : count + 3'd1;
         end
      end
   end

   // message and residue state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff    <= 1'b0;
         residue_bits_ff  <= 6'd0;
         residue_count_ff <= 3'd0;
      end else begin
         in_message_ff    <= in_message_in;
         residue_bits_ff  <= residue_bits_in;
         residue_count_ff <= residue_count_in;
      end
   end

endmodule

/* hw/rtl/sxp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxp_queue
// Short job queue between the front and back ends, so that either side can
// stall without holding up the other until the queue fills or runs empty.
// ----------------------------------------------------------------------------
module sxp_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sxp_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output sxp_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sxp_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/sxp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxp_back
// Steps through the queue head job one byte per cycle unless stalled: header
// if first, packed data, end marker if last; output reg reloads as it drains.
// ----------------------------------------------------------------------------
module sxp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  sxp_pkg::job_type head_job,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             run_last,
   output logic             message_end
);

   sxp_pkg::step_type step_ff, step_in, cur_step, next_step;
   logic       active_ff, active_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff, end_ff;
   logic [7:0] sel_byte;
   logic       final_step;
   logic       load;

   assign out_valid   = valid_ff;
   assign out_byte    = byte_ff;
   assign run_last    = last_ff;
   assign message_end = end_ff;

   assign load = head_valid && (!valid_ff || out_ready);
   assign pop  = load && final_step;

   // byte selection and step sequencing
   always_comb begin
      if (active_ff) begin
         cur_step = step_ff;
      end else begin
         cur_step = head_job.hdr ? sxp_pkg::STEP_START : sxp_pkg::STEP_D0;
      end

      sel_byte   = sxp_pkg::END_MARK;
      final_step = 1'b0;
      next_step  = sxp_pkg::STEP_END;
      unique case (cur_step)
         sxp_pkg::STEP_START: begin
            sel_byte  = sxp_pkg::HDR_START;
            next_step = sxp_pkg::STEP_T;
         end
         sxp_pkg::STEP_T: begin
            sel_byte  = sxp_pkg::HDR_T;
            next_step = sxp_pkg::STEP_H;
         end
         sxp_pkg::STEP_H: begin
            sel_byte  = sxp_pkg::HDR_H;
            next_step = sxp_pkg::STEP_ID;
         end
         sxp_pkg::STEP_ID: begin
            sel_byte  = head_job.msg_id;
            next_step = sxp_pkg::STEP_CTL;
         end
         sxp_pkg::STEP_CTL: begin
            sel_byte  = head_job.ctl;
            next_step = sxp_pkg::STEP_D0;
         end
         sxp_pkg::STEP_D0: begin
            sel_byte   = {1'b0, head_job.d0};
            final_step = !head_job.d1_en;
            next_step  = sxp_pkg::STEP_D1;
         end
         sxp_pkg::STEP_D1: begin
            sel_byte   = {1'b0, head_job.d1};
            final_step = !head_job.last;
            next_step  = sxp_pkg::STEP_END;
         end
         sxp_pkg::STEP_END: begin
            sel_byte   = sxp_pkg::END_MARK;
            final_step = 1'b1;
            next_step  = sxp_pkg::STEP_END;
         end
         default: begin
            sel_byte   = sxp_pkg::END_MARK;
            final_step = 1'b1;
            next_step  = sxp_pkg::STEP_END;
         end
      endcase

      step_in   = step_ff;
      active_in = active_ff;
      valid_in  = valid_ff;
      if (load) begin
         valid_in  = 1'b1;
         active_in = !final_step;
         step_in   = next_step;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= sxp_pkg::STEP_START;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         step_ff   <= step_in;
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= sel_byte;
         last_ff <= final_step;
         end_ff  <= (cur_step == sxp_pkg::STEP_END);
      end
   end

endmodule

/* hw/rtl/sysex_seven_bit_packer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sysex_seven_bit_packer_core
// Packs a payload byte stream into system-exclusive messages: header, 7-bit
// data bytes taken least significant bit first, flushed partial byte, 0xF7.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                 | tlast     | tuser
//  req     | in  | data_byte, msg_id, control_code       | last_byte | -
//  rsp     | out | out_byte                              | run_last  | message_end
//
//  one output byte per cycle while rsp is ready, from the single back-end
//  output register; an item gives 1 to 3 bytes, 5 more when it opens a message (header)
//  the front end accepts the next byte while the back end still drains,
//  up to QUEUE_DEPTH jobs ahead; synchronous reset clears state and queue
//  back pressure on rsp stalls the req side only once the queue fills
// ----------------------------------------------------------------------------
module sysex_seven_bit_packer_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte, msg_id, control_code
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser    // message_end
);

   sxp_pkg::job_type push_job, head_job;
   logic             push, pop, queue_full, head_valid;

   // accept and classify
   sxp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .data_byte    (req_tdata[7:0]),
      .msg_id       (req_tdata[15:8]),
      .control_code (req_tdata[23:16]),
      .last_byte    (req_tlast),
      .push         (push),
      .push_job     (push_job),
      .queue_full   (queue_full)
   );

   // job queue
   sxp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // byte emission
   sxp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .run_last    (rsp_tlast),
      .message_end (rsp_tuser)
   );

endmodule

/* verif/sxp_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxp_stream_checker
// Watches both streams of the sysex packer. It predicts the message bytes
// that each accepted payload byte must produce. It compares every rsp transfer
// with the oldest predicted byte and counts the mismatches.
// ----------------------------------------------------------------------------
module sxp_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte, msg_id, control_code
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // out_byte
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,   // message_end
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       message_end;
   } sysex_byte_type;

   // predicted message bytes, oldest first
   sysex_byte_type predicted_bytes[$];

   // packer state as seen by the predictor
   logic [5:0] carry_bits;
   logic [2:0] carry_count;
   logic       header_sent;
   int         errors;

   task automatic add_byte(input logic [7:0] value, input logic is_end);
      sysex_byte_type item;
      item.out_byte    = value;
      item.run_last    = 1'b0;
      item.message_end = is_end;
      predicted_bytes  = {predicted_bytes, item};
   endtask

   // header on the first byte, 7-bit repacking, flush and end marker on the last
   task automatic predict_payload_byte(input logic [7:0] data, input logic [7:0] id,
                                       input logic [7:0] ctl, input logic last);
      logic [15:0] acc;
      int unsigned bits_held;
      bits_held = carry_count;
      if (bits_held > 6) bits_held = 6;
      if (!header_sent) begin
         add_byte(sxp_pkg::HDR_START, 1'b0);
         add_byte(sxp_pkg::HDR_T, 1'b0);
         add_byte(sxp_pkg::HDR_H, 1'b0);
         add_byte(id, 1'b0);
         add_byte(ctl, 1'b0);
         header_sent = 1'b1;
         bits_held   = 0;
         carry_bits  = '0;
      end
      acc = {10'd0, carry_bits} | (16'(data) << bits_held);
      bits_held += 8;
      while (bits_held >= 7) begin
         add_byte({1'b0, acc[6:0]}, 1'b0);
         acc = acc >> 7;
         bits_held -= 7;
      end
      if (last) begin
         // partial byte only when bits are left over
         if (bits_held > 0) add_byte({1'b0, acc[6:0]}, 1'b0);
         add_byte(sxp_pkg::END_MARK, 1'b1);
         carry_bits  = '0;
         carry_count = '0;
         header_sent = 1'b0;
      end else begin
         carry_bits  = acc[5:0];
         carry_count = 3'(bits_held);
      end
      predicted_bytes[predicted_bytes.size() - 1].run_last = 1'b1;
   endtask

   always @(posedge clock) begin
      sysex_byte_type want;
      if (reset) begin
         predicted_bytes.delete();
         carry_bits  = '0;
         carry_count = '0;
         header_sent = 1'b0;
      end else begin
         // compare output transfer first, so a byte can never match its own cause
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp transfer: expected none, got %02h %b %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = predicted_bytes.pop_front();
               if (rsp_tdata !== want.out_byte || rsp_tlast !== want.run_last ||
                   rsp_tuser !== want.message_end) begin
                  errors++;
                  $display("%0t: rsp mismatch: expected %02h %b %b, got %02h %b %b",
                           $time, want.out_byte, want.run_last, want.message_end,
                           rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_payload_byte(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16], req_tlast);
      end
      mismatch_count <= errors;
      pending_count  <= predicted_bytes.size();
   end

endmodule

/* verif/sysex_seven_bit_packer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sysex_seven_bit_packer_core_tb
// Drives payload bytes into the sysex packer. A directed set comes first, then
// random messages under several idle and stall patterns, one of them a long
// receiver hold-off. The checker does the prediction and the comparison.
// ----------------------------------------------------------------------------
module sysex_seven_bit_packer_core_tb;

   localparam int LONG_HOLD = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // data_byte, msg_id, control_code
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // out_byte
   logic        rsp_tlast;
   logic        rsp_tuser;         // message_end

   int mismatch_count;
   int pending_count;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int items_sent    = 0;

   sysex_seven_bit_packer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   sxp_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // one payload byte, after a random idle gap, held until its transfer
   task automatic send_payload_byte(input logic [7:0] data, input logic [7:0] id,
                                    input logic [7:0] ctl, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ctl, id, data};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // random message; header fields change on every byte though only the first counts
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_payload_byte(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), i == len - 1);
   endtask

   // lengths biased to single bytes and to exact fill at seven
   task automatic send_random_messages(input int count);
      int pick;
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(9);
         if (pick < 2) send_message(1);
         else if (pick < 4) send_message(7);
         else if (pick < 5) send_message(14);
         else send_message($urandom_range(2, 12));
      end
   endtask

   // pause the sender until every predicted byte has been seen
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // timeout
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // stimulus and verdict
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes as single-byte messages
      send_payload_byte(8'h00, 8'h00, 8'h00, 1'b1);
      send_payload_byte(8'hFF, 8'hFF, 8'hFF, 1'b1);
      // two-byte message, header fields on the second byte ignored
      send_payload_byte(8'hA5, 8'h5A, 8'hC3, 1'b0);
      send_payload_byte(8'h3C, 8'hFF, 8'h00, 1'b1);
      // seven bytes fill whole 7-bit bytes: no partial byte before the end marker
      send_payload_byte(8'h55, 8'h01, 8'h80, 1'b0);
      send_payload_byte(8'hAA, 8'h00, 8'hFF, 1'b0);
      send_payload_byte(8'h01, 8'hFF, 8'h00, 1'b0);
      send_payload_byte(8'h80, 8'h12, 8'h34, 1'b0);
      send_payload_byte(8'h7F, 8'h56, 8'h78, 1'b0);
      send_payload_byte(8'hFE, 8'h9A, 8'hBC, 1'b0);
      send_payload_byte(8'hFF, 8'hDE, 8'hF0, 1'b1);
      // eight bytes: one leftover bit flushed
      for (int i = 0; i < 8; i++)
         send_payload_byte(8'hFF >> i, 8'h7E, 8'h81, i == 7);
      drain();

      // no idling, with a long receiver hold-off while the sender keeps offering
      req_idle_pct   = 0;
      rsp_stall_pct <= 0;
      send_random_messages(20);
      hold_requests <= hold_requests + 1;
      send_random_messages(90);
      drain();

      // sender idles
      req_idle_pct   = 49;
      rsp_stall_pct <= 0;
      send_random_messages(110);
      drain();

      // receiver stalls
      req_idle_pct   = 0;
      rsp_stall_pct <= 49;
      send_random_messages(110);
      drain();

      // both
      req_idle_pct   = 16;
      rsp_stall_pct <= 16;
      send_random_messages(110);
      drain();

      if (mismatch_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/sxp_pkg.sv
hw/rtl/sxp_front.sv
hw/rtl/sxp_queue.sv
hw/rtl/sxp_back.sv
hw/rtl/sysex_seven_bit_packer_core.sv
verif/sxp_stream_checker.sv
verif/sysex_seven_bit_packer_core_tb.sv
